// File: design/dna_pkg.sv
// ----------------------------------------------------------------------------
// dna_pkg
// shared operation and status codes for the dual number arithmetic unit
// ----------------------------------------------------------------------------
package dna_pkg;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDEF = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

endpackage

// File: design/dna_divider.sv
// ----------------------------------------------------------------------------
// dna_divider
// pipelined unsigned restoring divider with a carried sign flag, one quotient bit per stage
// ----------------------------------------------------------------------------
module dna_divider #(
   parameter int NUM_W = 96,
   parameter int DEN_W = 64,
   parameter int TAG_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  logic               in_neg,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]   in_den,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output logic               out_neg,
   output logic [NUM_W-1:0]   out_quo,
   output logic [TAG_W-1:0]   out_tag
);
   // stage k holds partial remainder, shifted numerator with quotient bits
   logic [NUM_W:0]     valid_ff;
   logic               neg_ff [NUM_W+1];
   logic [DEN_W-1:0]   rem_ff [NUM_W+1];
   logic [NUM_W-1:0]   num_ff [NUM_W+1];
   logic [DEN_W-1:0]   den_ff [NUM_W+1];
   logic [TAG_W-1:0]   tag_ff [NUM_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[NUM_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= '0;
         num_ff[0] <= in_num;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
         neg_ff[0] <= in_neg;
      end
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0] trial_in;
      logic [DEN_W:0] diff_in;
      always_comb begin
         trial_in = {rem_ff[k], num_ff[k][NUM_W-1]};
         diff_in  = trial_in - {1'b0, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!diff_in[DEN_W]) begin
               rem_ff[k+1] <= diff_in[DEN_W-1:0];
               num_ff[k+1] <= {num_ff[k][NUM_W-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= trial_in[DEN_W-1:0];
               num_ff[k+1] <= {num_ff[k][NUM_W-2:0], 1'b0};
            end
            den_ff[k+1] <= den_ff[k];
            tag_ff[k+1] <= tag_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_neg   = neg_ff[NUM_W];
   assign out_quo   = num_ff[NUM_W];
   assign out_tag   = tag_ff[NUM_W];
endmodule

// File: design/dual_number_alu_unit.sv
// ----------------------------------------------------------------------------
// dual_number_alu_unit
// fixed-point dual number add, subtract, multiply, divide and compare
// ----------------------------------------------------------------------------
// Every operation runs down one common pipeline so words leave in order. A
// word can enter every cycle while the response side does not stall; the
// depth is set by the bit-per-stage divider plus five further register
// stages. A stall on the response side holds the whole pipeline and drops
// req_ready in the same cycle, so no new word enters while the head word
// waits, bubbles or not. The dual part of a quotient is divided by b_real
// squared, so the divider numerator is 2*WORD_WIDTH+1+FRAC_BITS bits wide.
module dual_number_alu_unit #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_op,
   input  logic signed [WORD_WIDTH-1:0] req_a_real,
   input  logic signed [WORD_WIDTH-1:0] req_a_dual,
   input  logic signed [WORD_WIDTH-1:0] req_b_real,
   input  logic signed [WORD_WIDTH-1:0] req_b_dual,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [WORD_WIDTH-1:0] rsp_res_real,
   output logic signed [WORD_WIDTH-1:0] rsp_res_dual,
   output logic                         rsp_is_equal,
   output logic [1:0]                   rsp_status
);
   import dna_pkg::*;

   localparam int W   = WORD_WIDTH;
   localparam int PW  = 2 * W + 1;           // product magnitude incl. sum carry
   localparam int NW  = 2 * W + 1 + FRAC_BITS; // numerator of dual quotient
   localparam int DW  = 2 * W;               // divisor magnitude
   localparam int QW  = NW;
   // tag: op, undef, zero-divisor and equal flags plus sums and a pad bit
   localparam int TW  = 3 + 1 + 1 + 1 + 2 * (W + 1) + 1;

   // ---------------- stall control ----------------
   logic run;
   assign run       = !rsp_valid || rsp_ready;
   assign req_ready = run;

   // ---------------- stage 1: register operands ----------------
   logic             s1_v_ff;
   logic [2:0]       s1_op_ff;
   logic signed [W-1:0] s1_ar_ff, s1_ad_ff, s1_br_ff, s1_bd_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (run) s1_v_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (run) begin
         s1_op_ff <= req_op;
         s1_ar_ff <= req_a_real;
         s1_ad_ff <= req_a_dual;
         s1_br_ff <= req_b_real;
         s1_bd_ff <= req_b_dual;
      end
   end

   // ---------------- stage 2: products and sums ----------------
   logic             s2_v_ff;
   logic [2:0]       s2_op_ff;
   logic signed [W:0]    s2_sr_ff, s2_sd_ff;      // add / sub results
   logic signed [2*W-1:0] s2_p1_ff, s2_p2_ff, s2_p3_ff, s2_p4_ff; // ar*br ad*br ar*bd br*br
   logic signed [W-1:0]  s2_ar_ff, s2_ad_ff, s2_br_ff, s2_bd_ff;
   logic             s2_eq_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (run) s2_v_ff <= s1_v_ff;
   end
   always_ff @(posedge clock) begin
      if (run) begin
         s2_op_ff <= s1_op_ff;
         if (s1_op_ff == OP_SUB) begin
            s2_sr_ff <= {s1_ar_ff[W-1], s1_ar_ff} - {s1_br_ff[W-1], s1_br_ff};
            s2_sd_ff <= {s1_ad_ff[W-1], s1_ad_ff} - {s1_bd_ff[W-1], s1_bd_ff};
         end else begin
            s2_sr_ff <= {s1_ar_ff[W-1], s1_ar_ff} + {s1_br_ff[W-1], s1_br_ff};
            s2_sd_ff <= {s1_ad_ff[W-1], s1_ad_ff} + {s1_bd_ff[W-1], s1_bd_ff};
         end
         s2_p1_ff <= s1_ar_ff * s1_br_ff;
         s2_p2_ff <= s1_ad_ff * s1_br_ff;
         s2_p3_ff <= s1_ar_ff * s1_bd_ff;
         s2_p4_ff <= s1_br_ff * s1_br_ff;
         s2_ar_ff <= s1_ar_ff;
         s2_ad_ff <= s1_ad_ff;
         s2_br_ff <= s1_br_ff;
         s2_bd_ff <= s1_bd_ff;
         s2_eq_ff <= (s1_ar_ff == s1_br_ff) && (s1_ad_ff == s1_bd_ff);
      end
   end

   // ---------------- stage 3: combine, choose divider operands ----------------
   logic             s3_v_ff;
   logic [2:0]       s3_op_ff;
   logic signed [W:0] s3_sr_ff, s3_sd_ff;
   logic signed [PW-1:0] s3_mr_ff, s3_md_ff;        // full multiply products
   logic             s3_eq_ff;
   logic             s3_undef_ff, s3_zdiv_ff;
   logic signed [PW-1:0] s3_nd_ff;                  // ad*br - ar*bd
   logic signed [W-1:0]  s3_ar_ff, s3_ad_ff, s3_br_ff, s3_bd_ff;
   logic [DW-1:0]        s3_sq_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (run) s3_v_ff <= s2_v_ff;
   end
   always_ff @(posedge clock) begin
      if (run) begin
         s3_op_ff <= s2_op_ff;
         s3_sr_ff <= s2_sr_ff;
         s3_sd_ff <= s2_sd_ff;
         s3_eq_ff <= s2_eq_ff;
         s3_mr_ff <= PW'(s2_p1_ff);
         s3_md_ff <= PW'(s2_p2_ff) + PW'(s2_p3_ff);
         s3_nd_ff <= PW'(s2_p2_ff) - PW'(s2_p3_ff);
         s3_zdiv_ff  <= (s2_br_ff == '0);
         s3_undef_ff <= (s2_br_ff == '0) && !((s2_ar_ff == '0) && (s2_bd_ff != '0));
         s3_ar_ff <= s2_ar_ff;
         s3_ad_ff <= s2_ad_ff;
         s3_br_ff <= s2_br_ff;
         s3_bd_ff <= s2_bd_ff;
         s3_sq_ff <= DW'(s2_p4_ff);
      end
   end

   // magnitudes for both dividers
   function automatic logic [PW-1:0] mag_p(input logic signed [PW-1:0] v);
      return v[PW-1] ? PW'(-v) : v;
   endfunction
   function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
      return v[W-1] ? W'(-v) : v;
   endfunction

   logic          d1_neg, d2_neg;
   logic [NW-1:0] d1_num, d2_num;
   logic [DW-1:0] d1_den, d2_den;
   always_comb begin
      // real divider: (ar<<F)/br, or (ad<<F)/bd when br is zero
      if (s3_zdiv_ff) begin
         d1_neg = s3_ad_ff[W-1] ^ s3_bd_ff[W-1];
         d1_num = NW'({mag_w(s3_ad_ff), {FRAC_BITS{1'b0}}});
         d1_den = (s3_bd_ff == '0) ? DW'(1) : DW'(mag_w(s3_bd_ff));
      end else begin
         d1_neg = s3_ar_ff[W-1] ^ s3_br_ff[W-1];
         d1_num = NW'({mag_w(s3_ar_ff), {FRAC_BITS{1'b0}}});
         d1_den = DW'(mag_w(s3_br_ff));
      end
      d2_neg = s3_nd_ff[PW-1];
      d2_num = NW'({mag_p(s3_nd_ff), {FRAC_BITS{1'b0}}});
      d2_den = (s3_sq_ff == '0) ? DW'(1) : s3_sq_ff;
   end

   // tag carries everything else alongside the division
   logic [TW-1:0] tag_in, tag_out, tag2_unused;
   assign tag_in = {s3_op_ff, s3_undef_ff, s3_zdiv_ff, s3_eq_ff, s3_sr_ff, s3_sd_ff,
                    1'b0};

   // multiply results ride a second tag through the other divider
   localparam int MT = 2 * PW;
   logic [MT-1:0] mtag_out;

   logic          dv1_v, dv1_neg, dv2_v, dv2_neg;
   logic [QW-1:0] dv1_q, dv2_q;

   dna_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW)) u_div_real (
      .clock(clock), .reset(reset), .enable(run), .in_valid(s3_v_ff),
      .in_neg(d1_neg), .in_num(d1_num), .in_den(d1_den), .in_tag(tag_in),
      .out_valid(dv1_v), .out_neg(dv1_neg), .out_quo(dv1_q), .out_tag(tag_out)
   );
   dna_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(MT)) u_div_dual (
      .clock(clock), .reset(reset), .enable(run), .in_valid(s3_v_ff),
      .in_neg(d2_neg), .in_num(d2_num), .in_den(d2_den), .in_tag({s3_mr_ff, s3_md_ff}),
      .out_valid(dv2_v), .out_neg(dv2_neg), .out_quo(dv2_q), .out_tag(mtag_out)
   );
   assign tag2_unused = tag_out;

   // ---------------- stage 4: signed results at full width ----------------
   localparam int RW = QW + 2;
   logic          s4_v_ff;
   logic [2:0]    s4_op_ff;
   logic          s4_undef_ff, s4_eq_ff;
   logic signed [RW-1:0] s4_rr_ff, s4_rd_ff;
   logic [2:0]    t_op;
   logic          t_undef, t_zdiv, t_eq, t_pad;
   logic signed [W:0] t_sr, t_sd;
   logic signed [PW-1:0] t_mr, t_md;
   logic signed [RW-1:0] mr_sh, md_sh, q1_s, q2_s;
   assign {t_op, t_undef, t_zdiv, t_eq, t_sr, t_sd, t_pad} = tag2_unused;
   assign {t_mr, t_md} = mtag_out;
   always_comb begin
      // shifts truncate toward zero: shift magnitude, restore sign
      mr_sh = t_mr[PW-1] ? -RW'(mag_p(t_mr) >> FRAC_BITS) : RW'(mag_p(t_mr) >> FRAC_BITS);
      md_sh = t_md[PW-1] ? -RW'(mag_p(t_md) >> FRAC_BITS) : RW'(mag_p(t_md) >> FRAC_BITS);
      q1_s  = dv1_neg ? -RW'(dv1_q) : RW'(dv1_q);
      q2_s  = dv2_neg ? -RW'(dv2_q) : RW'(dv2_q);
   end
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (run) s4_v_ff <= dv1_v && dv2_v;
   end
   always_ff @(posedge clock) begin
      if (run) begin
         s4_op_ff    <= t_op;
         s4_undef_ff <= t_undef;
         s4_eq_ff    <= t_eq && !t_pad;
         unique case (t_op)
            OP_ADD, OP_SUB: begin
               s4_rr_ff <= RW'(t_sr);
               s4_rd_ff <= RW'(t_sd);
            end
            OP_MUL: begin
               s4_rr_ff <= mr_sh;
               s4_rd_ff <= md_sh;
            end
            OP_DIV: begin
               s4_rr_ff <= q1_s;
               s4_rd_ff <= t_zdiv ? '0 : q2_s;
            end
            default: begin
               s4_rr_ff <= '0;
               s4_rd_ff <= '0;
            end
         endcase
      end
   end

   // ---------------- stage 5: saturate, output register ----------------
   localparam logic signed [RW-1:0] MAXV = RW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);
   logic          ovr_r, ovr_d, arith;
   logic [W-1:0]  sat_r, sat_d;
   always_comb begin
      ovr_r = (s4_rr_ff > MAXV) || (s4_rr_ff < MINV);
      ovr_d = (s4_rd_ff > MAXV) || (s4_rd_ff < MINV);
      sat_r = ovr_r ? (s4_rr_ff[RW-1] ? W'(MINV) : W'(MAXV)) : W'(s4_rr_ff);
      sat_d = ovr_d ? (s4_rd_ff[RW-1] ? W'(MINV) : W'(MAXV)) : W'(s4_rd_ff);
      arith = (s4_op_ff == OP_ADD) || (s4_op_ff == OP_SUB) || (s4_op_ff == OP_MUL)
              || ((s4_op_ff == OP_DIV) && !s4_undef_ff);
   end

   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (run) rsp_valid_ff <= s4_v_ff;
   end
   always_ff @(posedge clock) begin
      if (run) begin
         rsp_res_real <= arith ? sat_r : '0;
         rsp_res_dual <= arith ? sat_d : '0;
         rsp_is_equal <= (s4_op_ff == OP_CMP) && s4_eq_ff;
         if (s4_op_ff == OP_DIV && s4_undef_ff) rsp_status <= ST_UNDEF;
         else if (arith && (ovr_r || ovr_d))    rsp_status <= ST_SAT;
         else                                   rsp_status <= ST_OK;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   // ---------------- assertions ----------------
   a_eq_only_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_equal |-> (rsp_res_real == '0) && (rsp_res_dual == '0))
      else $error("equal flag with nonzero result");
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_UNDEF) |-> (rsp_res_real == '0) && !rsp_is_equal)
      else $error("undefined division with data");
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dv1_v == dv2_v)
      else $error("dividers out of step");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(s4_v_ff))
      else $error("pipeline moved during stall");
endmodule

// File: dv/tb_dual_number_alu_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_number_alu_unit
// self-checking bench for the dual number arithmetic unit
// ----------------------------------------------------------------------------
// Words are driven through the request channel. Each accepted word is scored
// by a wide-integer model of the arithmetic, and the expectation is queued.
// Responses are checked in order against that queue, field by field. The run
// steps through directed corner cases, then random traffic under several idle
// and stall mixes, and then a long response hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_dual_number_alu_unit;
   import dna_pkg::*;

   localparam int          WW         = 32;
   localparam int          FB         = 16;
   localparam int          WATCHDOG   = 4000;
   localparam int          DRAIN      = 200;
   localparam int          HOLD_LEN   = 400;
   localparam logic [2:0]  OP_SPARE_0 = 3'd5;
   localparam logic [2:0]  OP_SPARE_1 = 3'd7;
   localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
   localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};
   localparam logic signed [WW-1:0] W_ONE = 1 <<< FB;

   typedef logic signed [191:0] wide_type;

   typedef struct packed {
      logic signed [WW-1:0] re;
      logic signed [WW-1:0] du;
      logic                 eq;
      logic [1:0]           st;
   } dn_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_op = OP_ADD;
   logic signed [WW-1:0] req_a_real = '0;
   logic signed [WW-1:0] req_a_dual = '0;
   logic signed [WW-1:0] req_b_real = '0;
   logic signed [WW-1:0] req_b_dual = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [WW-1:0] rsp_res_real;
   logic signed [WW-1:0] rsp_res_dual;
   logic                 rsp_is_equal;
   logic [1:0]           rsp_status;

   dn_result_type expected_q[$];
   int         mismatch_cnt = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   bit         hold_req = 0;
   int         hold_cnt = 0;
   int         quiet_cycles = 0;

   dual_number_alu_unit #(.WORD_WIDTH(WW), .FRAC_BITS(FB)) u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // saturate a wide value into the word range
   function automatic logic signed [WW-1:0] clamp_word(input wide_type v, inout logic sat);
      wide_type hi;
      wide_type lo;
      hi = W_MAX;
      lo = W_MIN;
      if (v > hi) begin
         sat = 1'b1;
         return W_MAX;
      end
      if (v < lo) begin
         sat = 1'b1;
         return W_MIN;
      end
      return v[WW-1:0];
   endfunction

   // exact arithmetic on wide integers; sv division truncates toward zero
   function automatic dn_result_type dual_arith(input logic [2:0] op,
         input logic signed [WW-1:0] a_r, a_d, b_r, b_d);
      dn_result_type r;
      wide_type   ar, ad, br, bd, xr, xd, scale;
      logic       sat;
      logic       arith;
      ar = a_r; ad = a_d; br = b_r; bd = b_d;
      scale = wide_type'(1) <<< FB;
      xr = '0; xd = '0;
      sat = 1'b0;
      arith = 1'b1;
      r = '0;
      r.st = ST_OK;
      unique case (op)
         OP_ADD: begin
            xr = ar + br;
            xd = ad + bd;
         end
         OP_SUB: begin
            xr = ar - br;
            xd = ad - bd;
         end
         OP_MUL: begin
            xr = (ar * br) / scale;
            xd = (ad * br + ar * bd) / scale;
         end
         OP_DIV: begin
            if (br != 0) begin
               xr = (ar * scale) / br;
               xd = ((ad * br - ar * bd) * scale) / (br * br);
            end else if (ar == 0 && bd != 0) begin
               // zero divisor real part with zero dividend real part
               xr = (ad * scale) / bd;
            end else begin
               arith = 1'b0;
               r.st = ST_UNDEF;
            end
         end
         OP_CMP: begin
            arith = 1'b0;
            r.eq = (a_r == b_r) && (a_d == b_d);
         end
         default: arith = 1'b0;
      endcase
      if (arith) begin
         r.re = clamp_word(xr, sat);
         r.du = clamp_word(xd, sat);
         if (sat) r.st = ST_SAT;
      end
      return r;
   endfunction

   // send one word, idling first at the current rate
   task automatic send_word(input logic [2:0] op,
         input logic signed [WW-1:0] a_r, a_d, b_r, b_d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_a_real <= a_r;
      req_a_dual <= a_d;
      req_b_real <= b_r;
      req_b_dual <= b_d;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(dual_arith(op, a_r, a_d, b_r, b_d));
   endtask

   function automatic logic signed [WW-1:0] pick_word();
      unique case ($urandom_range(9))
         0:       return '0;
         1:       return W_MAX;
         2:       return W_MIN;
         3:       return $urandom_range(1) ? W_ONE : -W_ONE;
         4, 5:    return WW'($signed($urandom_range(2 ** 20 - 1)) - (2 ** 19));
         6:       return WW'($signed($urandom_range(2 ** 24 - 1)) - (2 ** 23));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random();
      logic [2:0]           op;
      logic signed [WW-1:0] ar, ad, br, bd;
      op = ($urandom_range(39) == 0) ? 3'($urandom_range(OP_SPARE_0, OP_SPARE_1))
                                      : 3'($urandom_range(OP_CMP));
      ar = pick_word(); ad = pick_word(); br = pick_word(); bd = pick_word();
      if (op == OP_DIV && $urandom_range(5) == 0) begin
         br = '0;
         if ($urandom_range(1)) ar = '0;
      end
      if (op == OP_CMP && $urandom_range(1)) begin
         br = ar;
         bd = ad;
         if ($urandom_range(2) == 0) bd[$urandom_range(WW - 1)] ^= 1'b1;
      end
      send_word(op, ar, ad, br, bd);
   endtask

   // stop offering and wait for every expected word to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_word(OP_ADD, W_MAX, W_MIN, W_ONE, -W_ONE);
      send_word(OP_ADD, W_MIN, W_MAX, W_MIN, W_MAX);
      send_word(OP_SUB, W_MIN, W_MAX, W_ONE, -W_ONE);
      send_word(OP_SUB, 32'sd12345, -32'sd7, 32'sd12345, -32'sd7);
      send_word(OP_MUL, W_ONE * 3, W_ONE, W_ONE * 2, -W_ONE);
      send_word(OP_MUL, W_MAX, W_MAX, W_MAX, W_MAX);
      send_word(OP_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
      send_word(OP_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_word(OP_DIV, W_ONE * 7, W_ONE, W_ONE * 2, W_ONE);
      send_word(OP_DIV, -W_ONE, 32'sd3, W_ONE * 3, -32'sd5);
      send_word(OP_DIV, W_MAX, W_MAX, 32'sd1, W_MIN);
      send_word(OP_DIV, W_MIN, W_MIN, -32'sd1, W_MAX);
      // zero divisor real part, zero dividend real part
      send_word(OP_DIV, '0, W_ONE * 5, '0, W_ONE * 2);
      send_word(OP_DIV, '0, W_MIN, '0, 32'sd1);
      // undefined quotients
      send_word(OP_DIV, W_ONE, W_ONE, '0, W_ONE);
      send_word(OP_DIV, '0, W_ONE, '0, '0);
      send_word(OP_DIV, '0, '0, '0, '0);
      send_word(OP_CMP, W_MAX, W_MIN, W_MAX, W_MIN);
      send_word(OP_CMP, W_MAX, W_MIN, W_MAX, W_MIN + 1);
      send_word(OP_CMP, '0, '0, '0, '0);
      send_word(OP_CMP, 32'sd9, '0, 32'sd8, '0);
      send_word(OP_SPARE_0, W_MAX, W_MAX, W_MAX, W_MAX);
      send_word(OP_SPARE_1, W_MIN, W_ONE, '0, W_MIN);
      send_word(3'(OP_SPARE_0 + 1), 32'sd1, 32'sd1, 32'sd1, 32'sd1);
      wait_drained();
   endtask

   task automatic test_random(input int n, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n) send_random();
      wait_drained();
   endtask

   // hold responses off long enough to fill the pipeline and stall requests
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req = 1;
      repeat (200) send_random();
      wait_drained();
   endtask

   // response ready, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 0;
         hold_cnt = HOLD_LEN;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // scoreboard: compare each response word with the oldest expectation
   always @(posedge clock) begin
      dn_result_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: response word with nothing expected", $realtime);
         end else begin
            exp_w = expected_q.pop_front();
            if (rsp_res_real !== exp_w.re || rsp_res_dual !== exp_w.du ||
                  rsp_is_equal !== exp_w.eq || rsp_status !== exp_w.st) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display({"%0t: mismatch exp re=%h du=%h eq=%b st=%0d",
                            " got re=%h du=%h eq=%b st=%0d"},
                     $realtime, exp_w.re, exp_w.du, exp_w.eq, exp_w.st,
                     rsp_res_real, rsp_res_dual, rsp_is_equal, rsp_status);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
         $display("FAIL dual_number_alu_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300, 0, 0);
      test_random(300, 51, 0);
      test_random(300, 0, 51);
      test_random(300, 35, 35);
      test_backpressure();
      req_valid <= 1'b0;
      repeat (DRAIN) @(posedge clock);
      if (mismatch_cnt == 0 && expected_q.size() == 0) begin
         $display("PASS dual_number_alu_unit");
      end else begin
         $display("FAIL dual_number_alu_unit");
      end
      $finish;
   end

endmodule
